>>> hw/rtl/tld_pkg.sv
// Shared types and constants for the terminal line discipline.
// Holds flag bit positions, register indexes, character codes and the
// per-transaction action struct. No dependencies.
`default_nettype none
package tld_pkg;

    // Function codes of an input transaction
    localparam logic FUNC_RX  = 1'b0;
    localparam logic FUNC_POP = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_INPUT_FLAGS  = 3'd0;
    localparam logic [2:0] CFG_LOCAL_FLAGS  = 3'd1;
    localparam logic [2:0] CFG_EDIT_CHARS   = 3'd2;
    localparam logic [2:0] CFG_SIGNAL_CHARS = 3'd3;
    localparam logic [2:0] CFG_FLOW_CHARS   = 3'd4;
    localparam logic [2:0] CFG_MIN_COUNT    = 3'd5;

    // Input flag bits
    localparam int IF_STRIP = 0;
    localparam int IF_IGNCR = 1;
    localparam int IF_ICRNL = 2;
    localparam int IF_INLCR = 3;
    localparam int IF_IXON  = 4;
    localparam int IF_IXOFF = 5;
    localparam int IF_IXANY = 6;

    // Local flag bits
    localparam int LF_ISIG   = 0;
    localparam int LF_ICANON = 1;
    localparam int LF_ECHO   = 2;
    localparam int LF_ECHOE  = 3;
    localparam int LF_ECHOK  = 4;
    localparam int LF_ECHONL = 5;

    // Signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;
    localparam logic [1:0] SIG_SUSP = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_NL       = 8'h0A;
    localparam logic [7:0] CHAR_DISABLED = 8'hFF;
    localparam logic [7:0] CHAR_MASK7    = 8'h7F;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    // Reset values of the configuration registers
    localparam logic [6:0]  RST_INPUT_FLAGS  = 7'h54;
    localparam logic [5:0]  RST_LOCAL_FLAGS  = 6'h0F;
    localparam logic [31:0] RST_EDIT_CHARS   = 32'hFF04_1508;
    localparam logic [23:0] RST_SIGNAL_CHARS = 24'h1A_1C03;
    localparam logic [15:0] RST_FLOW_CHARS   = 16'h1311;
    localparam logic [7:0]  RST_MIN_COUNT    = 8'h01;

    // What one transaction does to the buffer state and what it reports
    typedef struct packed {
        logic       store;        // append the character at the write index
        logic       erase;        // drop the last held character
        logic       kill;         // drop every held character
        logic       pop;          // take the head character
        logic       set_stop;
        logic       clr_stop;
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       erase_one;    // report one visual erase
        logic       erase_all;    // report as many erases as were held
        logic [1:0] sig;
        logic       wake;
        logic       read_empty;
        logic [7:0] read_char;
        logic       read_deliver;
        logic       read_stop;
        logic       dc_we;
        logic [7:0] dc_next;
        logic [7:0] store_char;
    } t_tld_act;

    // Special character match; a disabled slot matches nothing
    function automatic logic chr_match(input logic [7:0] c, input logic [7:0] sc);
        chr_match = (sc != CHAR_DISABLED) && (c == sc);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/terminal_line_discipline_unit.sv
// Top level of the terminal line discipline: input register, decision
// logic, ring pointers and result register. Depends on tld_pkg,
// tld_core and tld_store.
`default_nettype none
// Each input transaction either delivers one received byte or pops one
// byte for a reader, and always yields exactly one result transaction.
// A transaction is held in an input register, decided in one pass of
// short logic (tld_core) and written to a result register, so a new
// transaction can be taken every cycle while results are
// accepted. The input side keeps taking transactions while
// a result waits, until the result register and the
// input register are both full. The ring of BUFFER_DEPTH characters is a
// single-port-write, single-port-read memory whose head byte is read ahead
// into a register, so a pop never waits on the memory; unwritten entries
// are never popped and need no clearing. Configuration is written through a
// plain write port (index 0 input flags, 1 local flags, 2 edit characters,
// 3 signal characters, 4 flow characters, 5 minimum count) and must only
// be written while no transaction is in flight.
module terminal_line_discipline_unit #(
    parameter int BUFFER_DEPTH = 256,
    localparam int HW = $clog2(BUFFER_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration write port
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    // input channel
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_func,
    input  wire logic [7:0]    i_rx_char,
    input  wire logic          i_read_start,
    // result channel
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_echo_valid,
    output logic [7:0]         o_echo_char,
    output logic [HW-1:0]      o_erase_echo_count,
    output logic [1:0]         o_signal_code,
    output logic               o_wake_reader,
    output logic               o_output_stopped,
    output logic               o_read_empty,
    output logic [7:0]         o_read_char,
    output logic               o_read_deliver,
    output logic               o_read_stop,
    output logic               o_readable,
    output logic [HW-1:0]      o_fill_level
);
    import tld_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] IDX_LAST  = AW'(BUFFER_DEPTH - 1);
    localparam logic [HW-1:0] HELD_LAST = HW'(BUFFER_DEPTH - 1);
    localparam logic [HW-1:0] HELD_FULL = HW'(BUFFER_DEPTH);

    // configuration registers
    logic [6:0]  r_input_flags;
    logic [5:0]  r_local_flags;
    logic [31:0] r_edit_chars;
    logic [23:0] r_signal_chars;
    logic [15:0] r_flow_chars;
    logic [7:0]  r_min_count;

    // input register
    logic        r_in_valid;
    logic        r_func;
    logic [7:0]  r_rx_char;
    logic        r_read_start;

    // line state
    logic [AW-1:0] r_widx, n_widx;
    logic [AW-1:0] r_ridx, n_ridx;
    logic [HW-1:0] r_held, n_held;
    logic          r_stopped, n_stopped;
    logic [7:0]    r_delivered, n_delivered;

    // result register
    logic          r_out_valid;
    logic          r_echo_valid;
    logic [7:0]    r_echo_char;
    logic [HW-1:0] r_erase_cnt;
    logic [1:0]    r_sig;
    logic          r_wake;
    logic          r_stopped_out;
    logic          r_read_empty;
    logic [7:0]    r_read_char;
    logic          r_read_deliver;
    logic          r_read_stop;
    logic          r_readable;
    logic [HW-1:0] r_fill;

    logic          fire;
    logic          in_take;
    logic [7:0]    head;
    t_tld_act      act;

    // Advance the held item whenever the result register is free or drains.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;

    tld_core u_core (
        .i_func         (r_func),
        .i_rx_char      (r_rx_char),
        .i_read_start   (r_read_start),
        .i_input_flags  (r_input_flags),
        .i_local_flags  (r_local_flags),
        .i_edit_chars   (r_edit_chars),
        .i_signal_chars (r_signal_chars),
        .i_flow_chars   (r_flow_chars),
        .i_min_count    (r_min_count),
        .i_held_zero    (r_held == '0),
        .i_held_last    (r_held == HELD_LAST),
        .i_held_full    (r_held >= HELD_FULL),
        .i_head         (head),
        .i_delivered    (r_delivered),
        .o_act          (act)
    );

    tld_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_we         (fire && act.store),
        .i_waddr      (r_widx),
        .i_wdata      (act.store_char),
        .i_raddr_next (n_ridx),
        .o_head       (head)
    );

    // Next line state; only a fired transaction moves anything.
    always_comb begin
        n_widx      = r_widx;
        n_ridx      = r_ridx;
        n_held      = r_held;
        n_stopped   = r_stopped;
        n_delivered = r_delivered;
        if (fire) begin
            if (act.store) begin
                n_widx = (r_widx == IDX_LAST) ? '0 : r_widx + 1'b1;
                n_held = r_held + 1'b1;
            end
            if (act.erase) begin
                n_widx = (r_widx == '0) ? IDX_LAST : r_widx - 1'b1;
                n_held = r_held - 1'b1;
            end
            if (act.kill) begin
                // drop everything held, unread earlier lines included
                n_widx = r_ridx;
                n_held = '0;
            end
            if (act.pop) begin
                n_ridx = (r_ridx == IDX_LAST) ? '0 : r_ridx + 1'b1;
                n_held = r_held - 1'b1;
            end
            if (act.set_stop) begin
                n_stopped = 1'b1;
            end else if (act.clr_stop) begin
                n_stopped = 1'b0;
            end
            if (act.dc_we) begin
                n_delivered = act.dc_next;
            end
        end
    end

    // configuration and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_flags  <= RST_INPUT_FLAGS;
            r_local_flags  <= RST_LOCAL_FLAGS;
            r_edit_chars   <= RST_EDIT_CHARS;
            r_signal_chars <= RST_SIGNAL_CHARS;
            r_flow_chars   <= RST_FLOW_CHARS;
            r_min_count    <= RST_MIN_COUNT;
            r_widx         <= '0;
            r_ridx         <= '0;
            r_held         <= '0;
            r_stopped      <= 1'b0;
            r_delivered    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INPUT_FLAGS:  r_input_flags  <= i_cfg_data[6:0];
                    CFG_LOCAL_FLAGS:  r_local_flags  <= i_cfg_data[5:0];
                    CFG_EDIT_CHARS:   r_edit_chars   <= i_cfg_data;
                    CFG_SIGNAL_CHARS: r_signal_chars <= i_cfg_data[23:0];
                    CFG_FLOW_CHARS:   r_flow_chars   <= i_cfg_data[15:0];
                    CFG_MIN_COUNT:    r_min_count    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_widx      <= n_widx;
            r_ridx      <= n_ridx;
            r_held      <= n_held;
            r_stopped   <= n_stopped;
            r_delivered <= n_delivered;
        end
    end

    // input register: hold until fired, refill in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func       <= i_func;
            r_rx_char    <= i_rx_char;
            r_read_start <= i_read_start;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_echo_valid   <= act.echo_valid;
            r_echo_char    <= act.echo_char;
            if (act.erase_all) begin
                r_erase_cnt <= r_held;
            end else begin
                r_erase_cnt <= HW'(act.erase_one);
            end
            r_sig          <= act.sig;
            r_wake         <= act.wake;
            r_stopped_out  <= n_stopped;
            r_read_empty   <= act.read_empty;
            r_read_char    <= act.read_char;
            r_read_deliver <= act.read_deliver;
            r_read_stop    <= act.read_stop;
            r_readable     <= (n_held != '0) && !r_local_flags[LF_ICANON];
            r_fill         <= n_held;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_echo_valid       = r_echo_valid;
    assign o_echo_char        = r_echo_char;
    assign o_erase_echo_count = r_erase_cnt;
    assign o_signal_code      = r_sig;
    assign o_wake_reader      = r_wake;
    assign o_output_stopped   = r_stopped_out;
    assign o_read_empty       = r_read_empty;
    assign o_read_char        = r_read_char;
    assign o_read_deliver     = r_read_deliver;
    assign o_read_stop        = r_read_stop;
    assign o_readable         = r_readable;
    assign o_fill_level       = r_fill;

endmodule
`default_nettype wire

>>> hw/rtl/tld_store.sv
// Character ring storage for the terminal line discipline.
// One write port and one read port with a registered head byte that
// follows the next read index; depends on nothing else.
`default_nettype none
module tld_store #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr_next,
    output logic      [7:0]    o_head
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_head;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // forward a same-cycle write so the head never goes stale
        if (i_we && (i_waddr == i_raddr_next)) begin
            r_head <= i_wdata;
        end else begin
            r_head <= r_mem[i_raddr_next];
        end
    end

    assign o_head = r_head;

endmodule
`default_nettype wire

>>> hw/rtl/tld_core.sv
// Character decision logic for the terminal line discipline.
// Maps, classifies and edits one received byte, or rules on one pop.
// Depends on tld_pkg.
`default_nettype none
module tld_core (
    input  wire logic              i_func,
    input  wire logic [7:0]        i_rx_char,
    input  wire logic              i_read_start,
    input  wire logic [6:0]        i_input_flags,
    input  wire logic [5:0]        i_local_flags,
    input  wire logic [31:0]       i_edit_chars,
    input  wire logic [23:0]       i_signal_chars,
    input  wire logic [15:0]       i_flow_chars,
    input  wire logic [7:0]        i_min_count,
    input  wire logic              i_held_zero,
    input  wire logic              i_held_last,
    input  wire logic              i_held_full,
    input  wire logic [7:0]        i_head,
    input  wire logic [7:0]        i_delivered,
    output tld_pkg::t_tld_act      o_act
);
    import tld_pkg::*;

    t_tld_act act;

    always_comb begin
        logic [7:0] c;
        logic       keep;
        logic       status;
        logic       done;
        logic       canon;
        logic       m_eof;
        logic       m_eol;
        logic       m_nl;
        logic       m_start;
        logic [7:0] dc_base;
        logic [7:0] dc_inc;

        act    = '0;
        canon  = i_local_flags[LF_ICANON];
        keep   = 1'b1;
        status = 1'b0;
        done   = 1'b0;

        // strip and CR/NL mapping
        c = i_rx_char;
        if (i_input_flags[IF_STRIP]) begin
            c = c & CHAR_MASK7;
        end
        if (c == CHAR_CR) begin
            if (i_input_flags[IF_IGNCR]) begin
                keep = 1'b0;
            end else if (i_input_flags[IF_ICRNL]) begin
                c = CHAR_NL;
            end
        end else if ((c == CHAR_NL) && i_input_flags[IF_INLCR]) begin
            c = CHAR_CR;
        end

        m_eof   = chr_match(c, i_edit_chars[23:16]);
        m_eol   = chr_match(c, i_edit_chars[31:24]);
        m_nl    = (c == CHAR_NL);
        m_start = chr_match(c, i_flow_chars[7:0]);
        act.store_char = c;

        dc_base = i_read_start ? 8'd0 : i_delivered;
        dc_inc  = (dc_base == COUNT_MAX) ? COUNT_MAX : dc_base + 8'd1;

        case (i_func)
            FUNC_RX: begin
                // canonical editing
                if (keep && canon) begin
                    if (chr_match(c, i_edit_chars[7:0])) begin
                        done = 1'b1;
                        if (!i_held_zero) begin
                            act.erase     = 1'b1;
                            act.erase_one = i_local_flags[LF_ECHOE];
                        end
                    end else if (chr_match(c, i_edit_chars[15:8])) begin
                        done          = 1'b1;
                        act.kill      = 1'b1;
                        act.erase_all = i_local_flags[LF_ECHOE];
                        if (i_local_flags[LF_ECHOK]) begin
                            act.echo_valid = 1'b1;
                            act.echo_char  = c;
                        end
                    end else begin
                        status = m_eof || m_eol || m_nl;
                    end
                end

                if (!done) begin
                    // flow control; stop wins over start
                    if (keep && (i_input_flags[IF_IXON] || i_input_flags[IF_IXOFF])) begin
                        if (chr_match(c, i_flow_chars[15:8])) begin
                            act.set_stop = 1'b1;
                            keep         = 1'b0;
                            if (i_input_flags[IF_IXOFF]) begin
                                act.echo_valid = 1'b1;
                                act.echo_char  = c;
                            end
                        end else if (m_start || i_input_flags[IF_IXANY]) begin
                            act.clr_stop = 1'b1;
                            if (m_start) begin
                                keep = 1'b0;
                                if (i_input_flags[IF_IXOFF]) begin
                                    act.echo_valid = 1'b1;
                                    act.echo_char  = c;
                                end
                            end
                        end
                    end

                    // signal characters
                    if (keep && i_local_flags[LF_ISIG]) begin
                        if (chr_match(c, i_signal_chars[7:0])) begin
                            act.sig = SIG_INTR;
                        end else if (chr_match(c, i_signal_chars[15:8])) begin
                            act.sig = SIG_QUIT;
                        end else if (chr_match(c, i_signal_chars[23:16])) begin
                            act.sig = SIG_SUSP;
                        end
                        if (act.sig != SIG_NONE) begin
                            act.echo_valid = 1'b1;
                            act.echo_char  = c;
                            keep           = 1'b0;
                        end
                    end

                    // echo and store, keeping one slot for a line end
                    if (keep) begin
                        if (!m_eof && i_local_flags[LF_ECHO]) begin
                            act.echo_valid = 1'b1;
                            act.echo_char  = c;
                        end else if (m_nl && i_local_flags[LF_ECHONL]) begin
                            act.echo_valid = 1'b1;
                            act.echo_char  = c;
                        end
                        if (i_held_last) begin
                            if (!canon || !(m_eol || m_eof || m_nl)) begin
                                keep = 1'b0;
                            end
                        end else if (i_held_full) begin
                            keep = 1'b0;
                        end
                        act.store = keep;
                    end

                    act.wake = status || !canon;
                end
            end
            FUNC_POP: begin
                act.dc_we   = 1'b1;
                act.dc_next = dc_base;
                if (i_held_zero) begin
                    act.read_empty = 1'b1;
                end else begin
                    act.pop       = 1'b1;
                    act.read_char = i_head;
                    if (canon) begin
                        if (chr_match(i_head, i_edit_chars[23:16])) begin
                            act.read_stop = 1'b1;
                        end else begin
                            act.read_deliver = 1'b1;
                            act.dc_next      = dc_inc;
                            act.read_stop    = chr_match(i_head, i_edit_chars[31:24])
                                               || (i_head == CHAR_NL);
                        end
                    end else begin
                        act.read_deliver = 1'b1;
                        act.dc_next      = dc_inc;
                        act.read_stop    = (dc_inc >= i_min_count);
                    end
                end
            end
            default: begin
                act = '0;
            end
        endcase
    end

    assign o_act = act;

endmodule
`default_nettype wire

>>> tb/sv/terminal_line_discipline_unit_test.sv
// Self-checking testbench for terminal_line_discipline_unit: receive and pop
// transactions over valid/ready, each result checked against a local model.
// Depends on tld_pkg and the terminal_line_discipline_unit RTL.
module terminal_line_discipline_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tld_pkg::*;

    localparam int DEPTH         = 256;
    localparam int HW            = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT   = 200_000;  // slowest correct run stays far below
    localparam int SETTLE_CYCLES = 6;        // input and result registers, with margin
    localparam int REPORT_LIMIT  = 10;

    // One result transaction, fields in port order
    typedef struct packed {
        logic          echo_valid;
        logic [7:0]    echo_char;
        logic [HW-1:0] erase_echo_count;
        logic [1:0]    signal_code;
        logic          wake_reader;
        logic          output_stopped;
        logic          read_empty;
        logic [7:0]    read_char;
        logic          read_deliver;
        logic          read_stop;
        logic          readable;
        logic [HW-1:0] fill_level;
    } t_line_outcome;

    // Register sets that a phase of mixed traffic can start from
    typedef enum int {
        PROFILE_RANDOM,
        PROFILE_ALL_CLEAR,
        PROFILE_ALL_SET,
        PROFILE_POWER_ON
    } t_profile;

    // ------------------------------------------------------------------
    // Clock, reset and the signals that drive the block
    // ------------------------------------------------------------------
    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          cfg_we        = 1'b0;
    logic [2:0]    cfg_idx       = CFG_INPUT_FLAGS;
    logic [31:0]   cfg_data      = '0;
    logic          in_valid      = 1'b0;
    logic          in_func       = FUNC_RX;
    logic [7:0]    in_rx_char    = '0;
    logic          in_read_start = 1'b0;
    logic          out_ready     = 1'b0;

    logic          o_in_ready;
    logic          o_out_valid;
    logic          o_echo_valid;
    logic [7:0]    o_echo_char;
    logic [HW-1:0] o_erase_echo_count;
    logic [1:0]    o_signal_code;
    logic          o_wake_reader;
    logic          o_output_stopped;
    logic          o_read_empty;
    logic [7:0]    o_read_char;
    logic          o_read_deliver;
    logic          o_read_stop;
    logic          o_readable;
    logic [HW-1:0] o_fill_level;

    always #4 clk = ~clk;

    terminal_line_discipline_unit #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (in_func),
        .i_rx_char          (in_rx_char),
        .i_read_start       (in_read_start),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_echo_valid       (o_echo_valid),
        .o_echo_char        (o_echo_char),
        .o_erase_echo_count (o_erase_echo_count),
        .o_signal_code      (o_signal_code),
        .o_wake_reader      (o_wake_reader),
        .o_output_stopped   (o_output_stopped),
        .o_read_empty       (o_read_empty),
        .o_read_char        (o_read_char),
        .o_read_deliver     (o_read_deliver),
        .o_read_stop        (o_read_stop),
        .o_readable         (o_readable),
        .o_fill_level       (o_fill_level)
    );

    // ------------------------------------------------------------------
    // Local model of the line discipline: register copies and ring state
    // ------------------------------------------------------------------
    logic [6:0]  in_flags   = RST_INPUT_FLAGS;
    logic [5:0]  lc_flags   = RST_LOCAL_FLAGS;
    logic [31:0] edit_bytes = RST_EDIT_CHARS;
    logic [23:0] sig_bytes  = RST_SIGNAL_CHARS;
    logic [15:0] flow_bytes = RST_FLOW_CHARS;
    logic [7:0]  min_chars  = RST_MIN_COUNT;

    logic [7:0]  line_mem [DEPTH];
    int unsigned write_ptr       = 0;
    int unsigned read_ptr        = 0;
    int unsigned held_chars      = 0;
    int unsigned delivered_chars = 0;
    logic        output_halted   = 1'b0;

    t_line_outcome awaited_outcomes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_sent       = 0;
    int pops_sent     = 0;
    int reg_writes    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int cycles        = 0;

    // A special character slot holding the disabled code matches nothing
    function automatic bit char_hits(input logic [7:0] c, input logic [7:0] slot);
        return (slot != CHAR_DISABLED) && (c == slot);
    endfunction

    // Advance the model by one input transaction and return its result
    function automatic t_line_outcome discipline_outcome(input logic func,
                                                         input logic [7:0] rx,
                                                         input logic rstart);
        t_line_outcome r;
        logic [7:0]    c;
        logic [7:0]    erase_ch, kill_ch, eof_ch, eol_ch, start_ch, stop_ch;
        logic [1:0]    sig;
        bit            canon, keep, line_end, edited, is_eof, start_hit;
        r        = '0;
        erase_ch = edit_bytes[7:0];
        kill_ch  = edit_bytes[15:8];
        eof_ch   = edit_bytes[23:16];
        eol_ch   = edit_bytes[31:24];
        start_ch = flow_bytes[7:0];
        stop_ch  = flow_bytes[15:8];
        canon    = lc_flags[LF_ICANON];

        if (func == FUNC_POP) begin
            if (rstart)
                delivered_chars = 0;
            if (held_chars == 0) begin
                r.read_empty = 1'b1;
            end else begin
                c          = line_mem[read_ptr];
                read_ptr   = (read_ptr + 1) % DEPTH;
                held_chars--;
                r.read_char = c;
                if (canon && char_hits(c, eof_ch)) begin
                    // end of file closes the read but is never handed over
                    r.read_stop = 1'b1;
                end else begin
                    r.read_deliver = 1'b1;
                    if (delivered_chars < COUNT_MAX)
                        delivered_chars++;
                    if (canon)
                        r.read_stop = char_hits(c, eol_ch) || c == CHAR_NL;
                    else
                        r.read_stop = delivered_chars >= min_chars;
                end
            end
        end else begin
            c        = rx;
            keep     = 1'b1;
            line_end = 1'b0;
            edited   = 1'b0;
            if (in_flags[IF_STRIP])
                c = c & CHAR_MASK7;
            if (c == CHAR_CR) begin
                if (in_flags[IF_IGNCR])
                    keep = 1'b0;
                else if (in_flags[IF_ICRNL])
                    c = CHAR_NL;
            end else if (c == CHAR_NL && in_flags[IF_INLCR]) begin
                c = CHAR_CR;
            end

            // canonical editing: erase and kill end the transaction here
            if (keep && canon) begin
                if (char_hits(c, erase_ch)) begin
                    edited = 1'b1;
                    if (held_chars > 0) begin
                        if (lc_flags[LF_ECHOE])
                            r.erase_echo_count = HW'(1);
                        held_chars--;
                        write_ptr = (write_ptr + DEPTH - 1) % DEPTH;
                    end
                end else if (char_hits(c, kill_ch)) begin
                    edited = 1'b1;
                    if (lc_flags[LF_ECHOE])
                        r.erase_echo_count = HW'(held_chars);
                    held_chars = 0;
                    write_ptr  = read_ptr;
                    if (lc_flags[LF_ECHOK]) begin
                        r.echo_valid = 1'b1; r.echo_char = c;
                    end
                end else begin
                    line_end = char_hits(c, eof_ch) || char_hits(c, eol_ch) || c == CHAR_NL;
                end
            end

            if (!edited) begin
                // flow control: stop halts, start (or any byte) restarts
                if (keep && (in_flags[IF_IXON] || in_flags[IF_IXOFF])) begin
                    start_hit = char_hits(c, start_ch);
                    if (char_hits(c, stop_ch)) begin
                        output_halted = 1'b1;
                        if (in_flags[IF_IXOFF]) begin
                            r.echo_valid = 1'b1; r.echo_char = c;
                        end
                        keep = 1'b0;
                    end else if (start_hit || in_flags[IF_IXANY]) begin
                        output_halted = 1'b0;
                        if (start_hit) begin
                            if (in_flags[IF_IXOFF]) begin
                                r.echo_valid = 1'b1; r.echo_char = c;
                            end
                            keep = 1'b0;
                        end
                    end
                end

                if (keep && lc_flags[LF_ISIG]) begin
                    sig = SIG_NONE;
                    if (char_hits(c, sig_bytes[7:0]))
                        sig = SIG_INTR;
                    else if (char_hits(c, sig_bytes[15:8]))
                        sig = SIG_QUIT;
                    else if (char_hits(c, sig_bytes[23:16]))
                        sig = SIG_SUSP;
                    if (sig != SIG_NONE) begin
                        r.signal_code = sig;
                        r.echo_valid  = 1'b1; r.echo_char = c;
                        keep          = 1'b0;
                    end
                end

                if (keep) begin
                    is_eof = char_hits(c, eof_ch);
                    if ((!is_eof && lc_flags[LF_ECHO]) || (c == CHAR_NL && lc_flags[LF_ECHONL])) begin
                        r.echo_valid = 1'b1; r.echo_char = c;
                    end
                    // the last free slot is kept for a canonical line end
                    if (held_chars == DEPTH - 1)
                        keep = canon && (char_hits(c, eol_ch) || is_eof || c == CHAR_NL);
                    else if (held_chars >= DEPTH)
                        keep = 1'b0;
                    if (keep) begin
                        line_mem[write_ptr] = c;
                        write_ptr = (write_ptr + 1) % DEPTH;
                        held_chars++;
                    end
                end
                r.wake_reader = line_end || !canon;
            end
        end

        r.output_stopped = output_halted;
        r.readable       = held_chars > 0 && !canon;
        r.fill_level     = HW'(held_chars);
        return r;
    endfunction

    function automatic string outcome_text(input t_line_outcome r);
        return {$sformatf("echo %0b/%02h erase %0d sig %0d wake %0b stopped %0b ",
                          r.echo_valid, r.echo_char, r.erase_echo_count, r.signal_code,
                          r.wake_reader, r.output_stopped),
                $sformatf("empty %0b char %02h deliver %0b end %0b readable %0b fill %0d",
                          r.read_empty, r.read_char, r.read_deliver, r.read_stop,
                          r.readable, r.fill_level)};
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the comparison of every result
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_line_outcome seen, want;
        if (rst_n && o_out_valid && out_ready) begin
            seen = {o_echo_valid, o_echo_char, o_erase_echo_count, o_signal_code,
                    o_wake_reader, o_output_stopped, o_read_empty, o_read_char,
                    o_read_deliver, o_read_stop, o_readable, o_fill_level};
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: result with nothing awaited: %s", outcome_text(seen));
            end else begin
                want = awaited_outcomes.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: result %0d differs\n  expected %s\n  actual   %s",
                                 results_seen, outcome_text(want), outcome_text(seen));
                end
            end
        end
        // stall the result channel with a chance of recv_idle_pct percent
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end a run that hangs
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles, %0d results still awaited",
                     cycles, awaited_outcomes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then record its result.
    // Returns on the accepting edge with valid still high.
    task automatic send_transaction(input logic func, input logic [7:0] ch,
                                    input logic rstart);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_func       <= func;
        in_rx_char    <= ch;
        in_read_start <= rstart;
        do @(posedge clk); while (!o_in_ready);
        awaited_outcomes.push_back(discipline_outcome(func, ch, rstart));
        if (func == FUNC_POP)
            pops_sent++;
        else
            rx_sent++;
    endtask

    // Drop valid, wait for every awaited result, then let the pipeline settle
    task automatic wait_until_settled();
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_INPUT_FLAGS:  in_flags   = value[6:0];
            CFG_LOCAL_FLAGS:  lc_flags   = value[5:0];
            CFG_EDIT_CHARS:   edit_bytes = value;
            CFG_SIGNAL_CHARS: sig_bytes  = value[23:0];
            CFG_FLOW_CHARS:   flow_bytes = value[15:0];
            CFG_MIN_COUNT:    min_chars  = value[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Write the whole register set, only ever with the block idle
    task automatic apply_settings(input logic [6:0] ifl, input logic [5:0] lfl,
                                  input logic [31:0] ed, input logic [23:0] sg,
                                  input logic [15:0] fl, input logic [7:0] mn);
        wait_until_settled();
        write_register(CFG_INPUT_FLAGS,  32'(ifl));
        write_register(CFG_LOCAL_FLAGS,  32'(lfl));
        write_register(CFG_EDIT_CHARS,   ed);
        write_register(CFG_SIGNAL_CHARS, 32'(sg));
        write_register(CFG_FLOW_CHARS,   32'(fl));
        write_register(CFG_MIN_COUNT,    32'(mn));
        cfg_we <= 1'b0;
    endtask

    // Special bytes: often control codes, sometimes disabled, sometimes anything
    function automatic logic [7:0] pick_special_byte();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return CHAR_DISABLED;
        if (r < 7)
            return 8'($urandom_range(31));
        return 8'($urandom_range(255));
    endfunction

    task automatic apply_profile(input t_profile kind);
        logic [5:0] lfl;
        logic [7:0] mn;
        int         r;
        case (kind)
            PROFILE_ALL_CLEAR: apply_settings('0, '0, '0, '0, '0, '0);
            PROFILE_ALL_SET:   apply_settings('1, '1, '1, '1, '1, '1);
            PROFILE_POWER_ON:  apply_settings(RST_INPUT_FLAGS, RST_LOCAL_FLAGS,
                                              RST_EDIT_CHARS, RST_SIGNAL_CHARS,
                                              RST_FLOW_CHARS, RST_MIN_COUNT);
            default: begin
                // mostly canonical, since editing and line ends live there
                lfl = 6'($urandom_range(63));
                if ($urandom_range(3) != 0)
                    lfl[LF_ICANON] = 1'b1;
                r = $urandom_range(5);
                if (r == 0)
                    mn = 8'h00;
                else if (r == 1)
                    mn = COUNT_MAX;
                else
                    mn = 8'($urandom_range(8, 1));
                apply_settings(7'($urandom_range(127)), lfl,
                               {pick_special_byte(), pick_special_byte(),
                                pick_special_byte(), pick_special_byte()},
                               {pick_special_byte(), pick_special_byte(),
                                pick_special_byte()},
                               {pick_special_byte(), pick_special_byte()}, mn);
            end
        endcase
    endtask

    // Received bytes: mostly text, with the current special characters mixed in
    function automatic logic [7:0] pick_rx_byte();
        logic [7:0] specials [13];
        int         r;
        specials = '{edit_bytes[7:0], edit_bytes[15:8], edit_bytes[23:16],
                     edit_bytes[31:24], sig_bytes[7:0], sig_bytes[15:8],
                     sig_bytes[23:16], flow_bytes[7:0], flow_bytes[15:8],
                     CHAR_CR, CHAR_NL, CHAR_DISABLED, 8'h00};
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(126, 32));
        if (r < 75)
            return specials[$urandom_range(12)];
        if (r < 90)
            return 8'($urandom_range(255));
        return CHAR_NL;
    endfunction

    // Pop until the ring is empty
    task automatic drain_line_store();
        while (held_chars != 0)
            send_transaction(FUNC_POP, 8'($urandom_range(255)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power-on registers: editing, flow control, signals and line ends
    task automatic test_power_on_behaviour();
        send_transaction(FUNC_POP, 8'h00, 1'b1);                   // pop on empty
        send_transaction(FUNC_RX, 8'h68, 1'b0);
        send_transaction(FUNC_RX, 8'h69, 1'b1);
        send_transaction(FUNC_RX, RST_EDIT_CHARS[7:0], 1'b0);      // erase one
        send_transaction(FUNC_RX, 8'h00, 1'b0);                    // zero byte is plain
        send_transaction(FUNC_RX, CHAR_DISABLED, 1'b0);            // matches no slot
        send_transaction(FUNC_RX, 8'h80, 1'b0);                    // strip is off
        send_transaction(FUNC_RX, RST_EDIT_CHARS[15:8], 1'b0);     // kill the line
        send_transaction(FUNC_RX, RST_EDIT_CHARS[7:0], 1'b0);      // erase on empty
        send_transaction(FUNC_RX, 8'h61, 1'b0);
        send_transaction(FUNC_RX, RST_FLOW_CHARS[15:8], 1'b0);     // stop output
        send_transaction(FUNC_RX, 8'h62, 1'b0);                    // any byte restarts
        send_transaction(FUNC_RX, RST_FLOW_CHARS[15:8], 1'b0);
        send_transaction(FUNC_RX, RST_FLOW_CHARS[7:0], 1'b0);      // start, consumed
        send_transaction(FUNC_RX, RST_SIGNAL_CHARS[7:0], 1'b0);
        send_transaction(FUNC_RX, RST_SIGNAL_CHARS[15:8], 1'b0);
        send_transaction(FUNC_RX, RST_SIGNAL_CHARS[23:16], 1'b0);
        send_transaction(FUNC_RX, CHAR_CR, 1'b0);                  // maps to newline
        send_transaction(FUNC_RX, RST_EDIT_CHARS[23:16], 1'b0);    // end of file
        send_transaction(FUNC_POP, 8'hFF, 1'b1);
        send_transaction(FUNC_POP, 8'h00, 1'b0);
        send_transaction(FUNC_POP, 8'h00, 1'b0);                   // newline ends read
        send_transaction(FUNC_POP, 8'h00, 1'b1);                   // end of file, kept back
        send_transaction(FUNC_POP, 8'h00, 1'b0);
    endtask

    // Canonical: fill to the reserved slot, land a line end in it, kill all
    task automatic test_canonical_limits();
        apply_settings('0, 6'((1 << LF_ICANON) | (1 << LF_ECHO) | (1 << LF_ECHOE)),
                       {CHAR_DISABLED, CHAR_DISABLED, RST_EDIT_CHARS[15:8], CHAR_DISABLED},
                       '1, '1, RST_MIN_COUNT);
        drain_line_store();
        repeat (DEPTH) send_transaction(FUNC_RX, 8'($urandom_range(126, 32)), 1'b0);
        send_transaction(FUNC_RX, CHAR_NL, 1'b0);                  // fits the last slot
        send_transaction(FUNC_RX, CHAR_NL, 1'b0);                  // ring full, dropped
        send_transaction(FUNC_RX, 8'($urandom_range(126, 32)), 1'b0);
        send_transaction(FUNC_RX, RST_EDIT_CHARS[15:8], 1'b0);     // kill a full ring
        repeat (30) send_transaction(FUNC_RX, 8'($urandom_range(126, 32)), 1'b0);
        send_transaction(FUNC_RX, CHAR_NL, 1'b0);
        send_transaction(FUNC_POP, 8'h00, 1'b1);
        drain_line_store();
        send_transaction(FUNC_POP, 8'h00, 1'b0);
    endtask

    // Non-canonical: fill, read it all in one read so the count tops out
    task automatic test_noncanonical_limits();
        apply_settings('0, 6'(1 << LF_ECHO), '1, '1, '1, COUNT_MAX);
        drain_line_store();
        repeat (DEPTH + 1) send_transaction(FUNC_RX, 8'($urandom_range(255)), 1'b0);
        send_transaction(FUNC_POP, 8'h00, 1'b1);
        drain_line_store();
        // hold the read open past the top of the count
        repeat (3) send_transaction(FUNC_RX, 8'($urandom_range(255)), 1'b0);
        drain_line_store();
        apply_settings('0, 6'(1 << LF_ECHO), '1, '1, '1, 8'h00);
        send_transaction(FUNC_POP, 8'h00, 1'b1);
        send_transaction(FUNC_RX, 8'($urandom_range(255)), 1'b1);
        send_transaction(FUNC_POP, 8'h00, 1'b0);
    endtask

    // Random receives and pops, with a fresh register set every few dozen
    task automatic test_mixed_traffic(input int count, input t_profile first);
        int sent;
        int until_change;
        int r;
        apply_profile(first);
        sent         = 0;
        until_change = $urandom_range(70, 30);
        while (sent < count) begin
            if (until_change == 0) begin
                r = $urandom_range(9);
                apply_profile(r == 0 ? PROFILE_ALL_CLEAR :
                              r == 1 ? PROFILE_ALL_SET :
                              r == 2 ? PROFILE_POWER_ON : PROFILE_RANDOM);
                until_change = $urandom_range(70, 30);
            end
            // pop harder when the ring runs full so both ends get exercised
            if ($urandom_range(99) < (held_chars > 200 ? 60 : 35))
                send_transaction(FUNC_POP, 8'($urandom_range(255)),
                                 1'($urandom_range(99) < 30));
            else
                send_transaction(FUNC_RX, pick_rx_byte(), 1'($urandom_range(1)));
            sent++;
            until_change--;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls often
        send_idle_pct = 26;
        recv_idle_pct = 47;
        test_power_on_behaviour();
        test_mixed_traffic(370, PROFILE_ALL_CLEAR);

        // and the other way round
        send_idle_pct = 47;
        recv_idle_pct = 26;
        test_canonical_limits();
        test_noncanonical_limits();
        test_mixed_traffic(370, PROFILE_ALL_SET);

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic(370, PROFILE_RANDOM);

        wait_until_settled();
        if (awaited_outcomes.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", awaited_outcomes.size());
        end

        $display("Run covered %0d receive and %0d pop transactions across %0d register writes",
                 rx_sent, pops_sent, reg_writes);
        $display("%0d results compared, %0d of them wrong or unexpected",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> terminal_line_discipline_unit.f
hw/rtl/tld_pkg.sv
hw/rtl/tld_store.sv
hw/rtl/tld_core.sv
hw/rtl/terminal_line_discipline_unit.sv
tb/sv/terminal_line_discipline_unit_test.sv
